>>> hw/rtl/wlk_pkg.sv
// ----------------------------------------------------------------------------
// wlk_pkg
// shared types and constants for the weighted l1 knn classifier
// ----------------------------------------------------------------------------
`default_nettype none
package wlk_pkg;

  localparam int LBL_W  = 7;
  localparam int VOTE_W = 5;
  localparam int IDX_W  = 12;
  localparam int VAL_W  = 32;
  localparam int WGT_W  = 24;
  localparam int DST_W  = 64;
  localparam int K_W    = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_WEIGHT = 2'd0,
    CMD_LOAD_QUERY  = 2'd1,
    CMD_REF_ELEM    = 2'd2,
    CMD_DECIDE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_MUL, S_ACC, S_VOTE, S_OUT
  } state_t;

  // one slot of the sorted neighbor list
  typedef struct packed {
    logic               valid;
    logic [DST_W-1:0]   distance;
    logic [LBL_W-1:0]   label;
  } entry_t;

  // insertion broadcast to every cell
  typedef struct packed {
    logic               go;
    logic               clear;
    logic [DST_W-1:0]   distance;
    logic [LBL_W-1:0]   label;
  } ins_t;

endpackage : wlk_pkg
`default_nettype wire

>>> hw/rtl/wlk_ram.sv
// ----------------------------------------------------------------------------
// wlk_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module wlk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : wlk_ram
`default_nettype wire

>>> hw/rtl/wlk_cell.sv
// ----------------------------------------------------------------------------
// wlk_cell
// one slot of the sorted nearest list, shifts toward the tail on insert
// ----------------------------------------------------------------------------
`default_nettype none
module wlk_cell
  import wlk_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire ins_t   ins,
  input  wire logic   prev_take,
  input  wire entry_t prev_entry,
  output logic        take,
  output entry_t      entry
);

  entry_t entry_r, entry_nxt;

  // strict compare keeps an earlier equal entry ahead
  assign take = ins.go && (!entry_r.valid || (ins.distance < entry_r.distance));

  always_comb begin
    entry_nxt = entry_r;
    if (ins.clear) begin
      entry_nxt.valid = 1'b0;
    end else if (prev_take) begin
      entry_nxt = prev_entry;
    end else if (take) begin
      entry_nxt = '{valid: 1'b1, distance: ins.distance, label: ins.label};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.distance <= entry_nxt.distance;
    entry_r.label    <= entry_nxt.label;
  end

  assign entry = entry_r;

endmodule : wlk_cell
`default_nettype wire

>>> hw/rtl/weighted_l1_knn_classifier_unit.sv
// ----------------------------------------------------------------------------
// weighted_l1_knn_classifier_unit
// weighted l1 k-nearest-neighbor classifier over a chain of sorted list cells
// ----------------------------------------------------------------------------
// sequencing: loads complete in the idle state; a reference element passes
//   through ram read, multiply, and accumulate with insert into the cell chain
// flow: in_tready stays low until that sequence ends, so reference elements
//   do not overlap; decide walks the voters one by one, then emits the result
// reset: rst_n synchronous, active low; clears the list, accumulator and
//   k to 1; weight and query memories are undefined until written
`default_nettype none
module weighted_l1_knn_classifier_unit
  import wlk_pkg::*;
#(
  parameter int FEATURES = 4096,
  parameter int MAX_K    = 16,
  parameter int LABELS   = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: k_neighbours
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [11:0] feature_index, [43:12] feature_value, [44] feature_missing,
  // [68:45] weight_value, [75:69] ref_label, [79:76] zero
  input  wire logic [79:0] in_tdata,
  // [1:0] command
  input  wire logic [1:0]  in_tuser,
  // last_feature
  input  wire logic        in_tlast,
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [6:0] predicted_label, [11:7] winning_votes, [15:12] zero
  output logic [15:0]      out_tdata,
  // [0] list_empty
  output logic [0:0]       out_tuser
);

  localparam int AW = (FEATURES > 1) ? $clog2(FEATURES) : 1;
  localparam int CW = $clog2(MAX_K + 1);
  localparam int JW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int QW = VAL_W + 1;

  // input field split
  logic [IDX_W-1:0] f_idx;
  logic [VAL_W-1:0] f_val;
  logic             f_miss;
  logic [WGT_W-1:0] f_wgt;
  logic [LBL_W-1:0] f_lbl;
  cmd_t             f_cmd;
  assign f_idx  = in_tdata[11:0];
  assign f_val  = in_tdata[43:12];
  assign f_miss = in_tdata[44];
  assign f_wgt  = in_tdata[68:45];
  assign f_lbl  = in_tdata[75:69];
  assign f_cmd  = cmd_t'(in_tuser);

  logic         accept;
  logic         in_range;
  logic [AW-1:0] addr;
  assign accept   = in_tvalid && in_tready;
  assign in_range = (32'(f_idx) < FEATURES);
  assign addr     = AW'(17'(f_idx));

  // weight and query memories
  logic [WGT_W-1:0] w_rdata;
  logic [QW-1:0]    q_rdata;

  wlk_ram #(.WIDTH(WGT_W), .DEPTH(FEATURES)) u_wram (
    .clk   (clk),
    .we    (accept && (f_cmd == CMD_LOAD_WEIGHT) && in_range),
    .waddr (addr),
    .wdata (f_wgt),
    .raddr (addr),
    .rdata (w_rdata)
  );

  wlk_ram #(.WIDTH(QW), .DEPTH(FEATURES)) u_qram (
    .clk   (clk),
    .we    (accept && (f_cmd == CMD_LOAD_QUERY) && in_range),
    .waddr (addr),
    .wdata ({f_miss, f_val}),
    .raddr (addr),
    .rdata (q_rdata)
  );

  // control and datapath registers
  state_t            state_r, state_nxt;
  logic [K_W-1:0]    k_r;
  logic [CW-1:0]     fill_r, fill_nxt;
  logic [DST_W-1:0]  acc_r, acc_nxt;
  logic [VAL_W-1:0]  val_r;
  logic              miss_r, range_r, last_r;
  logic [LBL_W-1:0]  lbl_r;
  logic [VAL_W:0]    mag_r;
  logic              use_r;
  logic [WGT_W-1:0]  w_r;
  logic [DST_W-1:0]  prod_r;
  logic [CW-1:0]     n_r, j_r;
  logic [LBL_W-1:0]  best_lbl_r;
  logic [CW-1:0]     best_cnt_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic              out_empty_r;

  // chain of list cells
  ins_t         ins;
  entry_t       cell_q  [MAX_K];
  logic [MAX_K:0] take_c;
  logic [MAX_K-1:0] match;

  assign take_c[0] = 1'b0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_cell
    entry_t prev_e;
    if (i == 0) begin : g_head
      assign prev_e = '0;
    end else begin : g_body
      assign prev_e = cell_q[i-1];
    end
    wlk_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ins        (ins),
      .prev_take  (take_c[i]),
      .prev_entry (prev_e),
      .take       (take_c[i+1]),
      .entry      (cell_q[i])
    );
    // voter i matches the candidate label
    assign match[i] = cell_q[i].valid && (CW'(i) < n_r) &&
                      (cell_q[i].label == cell_q[j_r[JW-1:0]].label);
  end

  // effective k and voter count at decide
  logic [CW-1:0] k_eff, n_now, cnt;
  always_comb begin
    if (k_r == '0) begin
      k_eff = CW'(1);
    end else if (32'(k_r) > MAX_K) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(k_r);
    end
    n_now = (fill_r < k_eff) ? fill_r : k_eff;
    cnt   = CW'($countones(match));
  end

  // datapath arithmetic
  logic signed [VAL_W:0] diff;
  logic [DST_W:0]        sum;
  logic [DST_W-1:0]      sum_sat;
  assign diff    = $signed({q_rdata[VAL_W-1], q_rdata[VAL_W-1:0]}) -
                   $signed({val_r[VAL_W-1], val_r});
  assign sum     = {1'b0, acc_r} + {1'b0, prod_r};
  assign sum_sat = sum[DST_W] ? '1 : sum[DST_W-1:0];

  logic lbl_ok;
  assign lbl_ok = (32'(lbl_r) < LABELS);

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    acc_nxt   = acc_r;
    fill_nxt  = fill_r;
    ins       = '{go: 1'b0, clear: 1'b0, distance: sum_sat, label: lbl_r};
    in_tready = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (accept && (f_cmd == CMD_REF_ELEM)) begin
          state_nxt = S_RD;
        end else if (accept && (f_cmd == CMD_DECIDE)) begin
          state_nxt = (n_now == '0) ? S_OUT : S_VOTE;
        end
      end
      S_RD:  state_nxt = S_MUL;
      S_MUL: state_nxt = S_ACC;
      S_ACC: begin
        state_nxt = S_IDLE;
        if (last_r) begin
          acc_nxt = '0;
          if (lbl_ok) begin
            ins.go = 1'b1;
            if (fill_r != CW'(MAX_K)) begin
              fill_nxt = fill_r + CW'(1);
            end
          end
        end else begin
          acc_nxt = sum_sat;
        end
      end
      S_VOTE: begin
        if (j_r + CW'(1) == n_r) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ins.clear = 1'b1;
          fill_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= K_W'(1);
      fill_r      <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      acc_r   <= acc_nxt;
      if (cfg_we) begin
        k_r <= cfg_wdata;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      val_r      <= f_val;
      miss_r     <= f_miss;
      range_r    <= in_range;
      last_r     <= in_tlast;
      lbl_r      <= f_lbl;
      n_r        <= n_now;
      j_r        <= '0;
      best_cnt_r <= '0;
      best_lbl_r <= '0;
    end
    if (state_r == S_RD) begin
      mag_r <= diff[VAL_W] ? (VAL_W+1)'(-diff) : (VAL_W+1)'(diff);
      use_r <= range_r && !miss_r && !q_rdata[VAL_W];
      w_r   <= w_rdata;
    end
    if (state_r == S_MUL) begin
      prod_r <= use_r ? DST_W'(mag_r * w_r) : '0;
    end
    if (state_r == S_VOTE) begin
      j_r <= j_r + CW'(1);
      // more votes wins, equal votes go to the lower label
      if ((cnt > best_cnt_r) || ((cnt == best_cnt_r) &&
          (cell_q[j_r[JW-1:0]].label < best_lbl_r))) begin
        best_cnt_r <= cnt;
        best_lbl_r <= cell_q[j_r[JW-1:0]].label;
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r  <= {4'b0, VOTE_W'(best_cnt_r), best_lbl_r};
      out_empty_r <= (n_r == '0);
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_empty_r;

  // the list never holds more than MAX_K entries
  assert property (@(posedge clk) disable iff (!rst_n) fill_r <= CW'(MAX_K))
    else $error("fill count above list depth");

  // a new result always finds the list cleared
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (fill_r == '0))
    else $error("list not cleared on decide");

  // an empty list reports label zero with no votes
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[11:0] == 12'd0))
    else $error("empty result carries a label");

endmodule : weighted_l1_knn_classifier_unit
`default_nettype wire

>>> dv/weighted_l1_knn_classifier_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_l1_knn_classifier_checker
// watches the input, config and result channels of the knn classifier, keeps
// its own weight and query memories and sorted neighbor list, and compares
// every decide result with the predicted vote
// ----------------------------------------------------------------------------
module weighted_l1_knn_classifier_checker
  import wlk_pkg::*;
#(
  parameter int FEATURES = 4096,
  parameter int MAX_K    = 16,
  parameter int LABELS   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic [0:0]  out_tuser,
  output int          fail_count,
  output int          pending_votes
);

  typedef struct packed {
    logic [6:0] label;
    logic [4:0] votes;
    logic       empty;
  } vote_t;

  logic [23:0] wgt_mem [FEATURES];
  logic [32:0] qry_mem [FEATURES];
  logic [63:0] acc;
  logic [63:0] nn_dist [MAX_K];
  logic [6:0]  nn_label [MAX_K];
  int          nn_fill;
  logic [4:0]  k_reg;
  vote_t       vote_q[$];

  assign pending_votes = vote_q.size();

  task automatic clear_nearest();
    for (int i = 0; i < MAX_K; i++) begin
      nn_dist[i] = '1;
      nn_label[i] = '0;
    end
    nn_fill = 0;
  endtask

  // stable insert: equal distances keep the older entry ahead
  task automatic insert_nearest(logic [63:0] d, logic [6:0] lbl);
    int pos;
    int top;
    pos = 0;
    while (pos < nn_fill && pos < MAX_K && nn_dist[pos] <= d) pos++;
    if (pos < MAX_K) begin
      top = (nn_fill < MAX_K) ? nn_fill : MAX_K - 1;
      for (int i = top; i > pos; i--) begin
        nn_dist[i] = nn_dist[i-1];
        nn_label[i] = nn_label[i-1];
      end
      nn_dist[pos] = d;
      nn_label[pos] = lbl;
      if (nn_fill < MAX_K) nn_fill++;
    end
  endtask

  function automatic vote_t tally_vote();
    int votes [LABELS];
    int k;
    int n;
    vote_t r;
    k = (k_reg < 1) ? 1 : (k_reg > MAX_K ? MAX_K : k_reg);
    n = (nn_fill < k) ? nn_fill : k;
    foreach (votes[i]) votes[i] = 0;
    for (int i = 0; i < n; i++) votes[nn_label[i]]++;
    r = '0;
    for (int i = 0; i < LABELS; i++)
      if (votes[i] > r.votes) begin
        r.votes = 5'(votes[i]);
        r.label = 7'(i);
      end
    r.empty = (n == 0);
    return r;
  endfunction

  task automatic apply_word();
    logic [11:0]        idx;
    logic signed [31:0] fval;
    logic               fmiss;
    logic [23:0]        wval;
    logic [6:0]         lbl;
    logic signed [33:0] diff;
    logic [63:0]        term;
    logic [64:0]        sum;
    idx   = in_tdata[11:0];
    fval  = in_tdata[43:12];
    fmiss = in_tdata[44];
    wval  = in_tdata[68:45];
    lbl   = in_tdata[75:69];
    case (cmd_t'(in_tuser))
      CMD_LOAD_WEIGHT: if (idx < FEATURES) wgt_mem[idx] = wval;
      CMD_LOAD_QUERY:  if (idx < FEATURES) qry_mem[idx] = {fmiss, fval};
      CMD_REF_ELEM: begin
        if (idx < FEATURES && !fmiss && !qry_mem[idx][32]) begin
          diff = $signed(qry_mem[idx][31:0]) - fval;
          if (diff < 0) diff = -diff;
          term = 64'(diff) * 64'(wgt_mem[idx]);
          sum = {1'b0, acc} + {1'b0, term};
          acc = sum[64] ? '1 : sum[63:0];
        end
        if (in_tlast) begin
          if (lbl < LABELS) insert_nearest(acc, lbl);
          acc = '0;
        end
      end
      CMD_DECIDE: begin
        vote_q.push_back(tally_vote());
        clear_nearest();
      end
    endcase
  endtask

  always @(posedge clk) begin
    vote_t exp_v;
    vote_t got;
    if (!rst_n) begin
      acc = '0;
      clear_nearest();
      k_reg = 5'd1;
      vote_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) k_reg = cfg_wdata;
      if (out_tvalid && out_tready) begin
        got = {out_tdata[6:0], out_tdata[11:7], out_tuser[0]};
        if (vote_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_v = vote_q.pop_front();
          if (got !== exp_v || out_tdata[15:12] !== 4'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp label %0d votes %0d empty %0d, got label %0d votes %0d empty %0d",
                       exp_v.label, exp_v.votes, exp_v.empty,
                       got.label, got.votes, got.empty);
          end
        end
      end
      if (in_tvalid && in_tready) apply_word();
    end
  end

endmodule

>>> dv/weighted_l1_knn_classifier_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// weighted_l1_knn_classifier_unit_tb
// drives loads, reference vectors and decide words into the classifier under
// random bursts and output stalls; the checker predicts every vote result
// ----------------------------------------------------------------------------
module weighted_l1_knn_classifier_unit_tb;
  import wlk_pkg::*;

  localparam int NFEAT = 8;   // features actually used per query

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // idx, value, missing, weight, label, zero
  logic [1:0]  in_tuser;   // command
  logic        in_tlast;   // last_feature
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // label, votes, zero
  logic [0:0]  out_tuser;  // list_empty
  int          fail_count;
  int          pending_votes;
  int          words_sent;
  int          hold_off;   // long receiver stall, in cycles
  bit          gaps_on;

  weighted_l1_knn_classifier_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  weighted_l1_knn_classifier_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast), .out_tvalid(out_tvalid),
    .out_tready(out_tready), .out_tdata(out_tdata), .out_tuser(out_tuser),
    .fail_count(fail_count), .pending_votes(pending_votes)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // generous overall limit
  initial begin
    #4000000;
    $display("weighted_l1_knn_classifier_unit regression: fail");
    $finish;
  end

  // receiver: own stall pattern, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_tready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (gaps_on)
        out_tready <= ($urandom_range(0, 3) != 0);
      else
        out_tready <= 1'b1;
    end
  end

  // one word through the handshake; sender bursts with random gaps when gaps_on
  task automatic send_word(cmd_t cmd, logic [11:0] idx, logic [31:0] val,
                           logic miss, logic [23:0] wgt, logic [6:0] lbl,
                           logic last);
    if (gaps_on && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'd0, lbl, wgt, miss, val, idx};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_votes != 0) @(posedge clk);
    repeat (40) @(posedge clk);  // decide walks the list after its word
  endtask

  task automatic set_k(logic [4:0] k);
    go_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= k;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 255) - 128;
      default: return $urandom;
    endcase
  endfunction

  // loads weights and query for every used feature and for feature 4095
  task automatic load_query(bit extreme);
    for (int f = 0; f < NFEAT; f++) begin
      send_word(CMD_LOAD_WEIGHT, 12'(f), $urandom, 1'($urandom_range(0, 1)),
                extreme ? 24'hffffff : 24'($urandom), 7'($urandom), 1'($urandom));
      send_word(CMD_LOAD_QUERY, 12'(f), extreme ? 32'h8000_0000 : rand_value(),
                $urandom_range(0, 7) == 0, 24'($urandom), 7'($urandom),
                1'($urandom));
    end
    send_word(CMD_LOAD_WEIGHT, 12'd4095, $urandom, 1'b0, 24'($urandom), 7'd0, 1'b0);
    send_word(CMD_LOAD_QUERY, 12'd4095, $urandom, 1'($urandom_range(0, 1)), 24'd0,
              7'd0, 1'b0);
  endtask

  // one reference vector over the used features, random length
  task automatic send_ref(logic [6:0] lbl, bit extreme);
    int n;
    n = $urandom_range(1, NFEAT);
    for (int f = 0; f < n; f++)
      send_word(CMD_REF_ELEM, ($urandom_range(0, 19) == 0) ? 12'd4095 : 12'(f),
                extreme ? 32'h7fff_ffff : rand_value(),
                $urandom_range(0, 7) == 0, 24'($urandom), lbl, f == n - 1);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_LOAD_WEIGHT;
    in_tlast = 1'b0;
    hold_off = 0;
    gaps_on = 1'b0;
    words_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: decide on an empty list, extreme values
    send_word(CMD_DECIDE, 0, 0, 0, 0, 0, 0);
    load_query(1);
    send_ref(7'd127, 1);
    send_ref(7'd3, 0);
    send_word(CMD_REF_ELEM, 0, 0, 0, 0, 7'd5, 1);  // single-element reference vector with label 5
    send_word(CMD_DECIDE, 0, 0, 0, 0, 0, 0);
    set_k(5'd0);
    send_ref(7'd9, 0);
    send_ref(7'd9, 0);
    send_word(CMD_REF_ELEM, 1, 5, 0, 0, 7'd2, 0);  // decide mid-reference
    send_word(CMD_DECIDE, 0, 0, 0, 0, 0, 0);
    send_word(CMD_REF_ELEM, 2, 7, 0, 0, 7'd2, 1);
    send_word(CMD_DECIDE, 0, 0, 0, 0, 0, 0);

    gaps_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_k(5'd16);
        1: set_k(5'd31);
        2: set_k(5'd1);
        default: set_k(5'($urandom_range(0, 31)));
      endcase
      load_query(0);
      if (ph == 3) hold_off = 300;  // long receiver stall holds the block at its output and stalls its input
      while (words_sent < 280 * (ph + 1)) begin
        int nref;
        nref = $urandom_range(0, 22);
        // few labels so ties and duplicates appear often
        for (int r = 0; r < nref; r++)
          send_ref(($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 3)), 0);
        if ($urandom_range(0, 9) == 0)
          send_word(CMD_LOAD_QUERY, 12'($urandom_range(0, NFEAT - 1)), rand_value(),
                    1'($urandom_range(0, 1)), 24'd0, 7'd0, 1'b0);
        send_word(CMD_DECIDE, 12'($urandom), $urandom, 1'($urandom), 24'($urandom),
                  7'($urandom), 1'($urandom));
        if ($urandom_range(0, 5) == 0) go_quiet();
      end
    end

    go_quiet();
    if (fail_count == 0)
      $display("weighted_l1_knn_classifier_unit regression: pass");
    else
      $display("weighted_l1_knn_classifier_unit regression: fail");
    $finish;
  end

endmodule
